>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Holds at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/brc_pkg.sv
// ----------------------------------------------------------------------------
// Byte recurrence checksum package
// Widths, constants, step struct and the mod 65535 reduction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned TERM_W   = 16;
    localparam int unsigned INDEX_W  = 8;
    localparam int unsigned SUM_W    = BYTE_W + 1;
    localparam int unsigned POS_W    = SUM_W + TERM_W;
    localparam int unsigned NEG_W    = INDEX_W + TERM_W;

    localparam logic [TERM_W-1:0]  MODULUS      = 16'hFFFF;
    localparam logic [TERM_W-1:0]  FIRST_OFFSET = 16'd7;
    localparam logic [INDEX_W-1:0] ALPHA_MULT   = 8'd17;
    localparam logic [INDEX_W-1:0] BETA_MULT    = 8'd31;
    localparam logic [TERM_W-1:0]  TERM_RESET   = 16'd1;

    typedef struct packed {
        logic              fire;
        logic              first;
        logic [BYTE_W-1:0] data_byte;
    } t_step;

    // Residue mod 2^16-1 by end-around-carry folding.
    function automatic logic [TERM_W-1:0] mod_fold(input logic [POS_W-1:0] v);
        logic [TERM_W:0] s1;
        logic [TERM_W:0] s2;
        s1 = {1'b0, v[TERM_W-1:0]} + {{(TERM_W+1-(POS_W-TERM_W)){1'b0}}, v[POS_W-1:TERM_W]};
        s2 = {1'b0, s1[TERM_W-1:0]} + {{TERM_W{1'b0}}, s1[TERM_W]};
        if (s2 >= {1'b0, MODULUS}) begin
            s2 = s2 - {1'b0, MODULUS};
        end
        return s2[TERM_W-1:0];
    endfunction

endpackage

>>> rtl/brc_core.sv
// ----------------------------------------------------------------------------
// Byte recurrence checksum core
// Holds the recurrence state and folds in one byte per fired step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brc_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  brc_pkg::t_step                i_step,
    output logic [brc_pkg::TERM_W-1:0]    o_term
);

    logic [brc_pkg::TERM_W-1:0]  r_previous, n_previous;
    logic [brc_pkg::TERM_W-1:0]  r_current,  n_current;
    logic [brc_pkg::INDEX_W-1:0] r_index,    n_index;

    logic [2*brc_pkg::INDEX_W-1:0] alpha_prod;
    logic [2*brc_pkg::INDEX_W-1:0] beta_prod;
    logic [brc_pkg::SUM_W-1:0]     coef;
    logic [brc_pkg::POS_W-1:0]     pos;
    logic [brc_pkg::POS_W-1:0]     neg;
    logic                          is_neg;
    logic [brc_pkg::TERM_W-1:0]    res_pos;
    logic [brc_pkg::TERM_W-1:0]    res_neg_fold;
    logic [brc_pkg::TERM_W-1:0]    term;

    always_comb begin
        alpha_prod = {{brc_pkg::INDEX_W{1'b0}}, r_index}
                   * {{brc_pkg::INDEX_W{1'b0}}, brc_pkg::ALPHA_MULT};
        beta_prod  = {{brc_pkg::INDEX_W{1'b0}}, r_index}
                   * {{brc_pkg::INDEX_W{1'b0}}, brc_pkg::BETA_MULT};
        coef = {1'b0, i_step.data_byte} + {1'b0, alpha_prod[brc_pkg::INDEX_W-1:0]};
        pos  = {{brc_pkg::TERM_W{1'b0}}, coef}
             * {{brc_pkg::SUM_W{1'b0}}, r_current};
        neg  = {{(brc_pkg::POS_W-brc_pkg::NEG_W){1'b0}},
                {{(brc_pkg::NEG_W-brc_pkg::INDEX_W){1'b0}}, beta_prod[brc_pkg::INDEX_W-1:0]}
                * {{(brc_pkg::NEG_W-brc_pkg::TERM_W){1'b0}}, r_previous}};
        is_neg = pos < neg;
        res_pos = brc_pkg::mod_fold(pos - neg);
        // A negative difference is treated as wrapping through 2^64, which is 1 mod 65535:
        // the residue is minus (neg - pos - 1) reduced.
        res_neg_fold = brc_pkg::mod_fold(neg - pos - {{(brc_pkg::POS_W-1){1'b0}}, 1'b1});
        if (!is_neg) begin
            term = res_pos;
        end else if (res_neg_fold == '0) begin
            term = '0;
        end else begin
            term = brc_pkg::MODULUS - res_neg_fold;
        end
    end

    always_comb begin
        n_previous = r_previous;
        n_current  = r_current;
        n_index    = r_index;
        if (i_step.fire) begin
            if (i_step.first) begin
                n_previous = brc_pkg::TERM_RESET;
                n_current  = {{(brc_pkg::TERM_W-brc_pkg::BYTE_W){1'b0}}, i_step.data_byte}
                           + brc_pkg::FIRST_OFFSET;
                n_index    = {{(brc_pkg::INDEX_W-1){1'b0}}, 1'b1};
            end else begin
                n_previous = r_current;
                n_current  = term;
                n_index    = r_index + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_previous <= brc_pkg::TERM_RESET;
            r_current  <= brc_pkg::TERM_RESET;
            r_index    <= '0;
        end else begin
            r_previous <= n_previous;
            r_current  <= n_current;
            r_index    <= n_index;
        end
    end

    assign o_term = n_current;

endmodule

>>> rtl/byte_recurrence_checksum_top.sv
// ----------------------------------------------------------------------------
// Byte recurrence checksum top level
// Stream wrapper: input register, recurrence core, output register.
// ----------------------------------------------------------------------------
// A last byte is held in the input register, its checksum in the output register.
// Throughput: one byte per cycle while no last byte waits; the recurrence closes
// combinationally through the core's two multipliers and end-around-carry reduction.
// A last byte waits in the input register only while an earlier checksum is held.
// Reset (synchronous, active low) empties both registers and sets the state
// to previous = 1, current = 1, index = 0.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module byte_recurrence_checksum_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [brc_pkg::BYTE_W-1:0]   i_s_tdata,   // [7:0] data_byte
    input  logic                         i_s_tuser,   // [0] first
    input  logic                         i_s_tlast,   // last byte of the message
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [brc_pkg::TERM_W-1:0]   o_m_tdata    // [15:0] checksum
);

    logic                         r_in_valid;
    logic [brc_pkg::BYTE_W-1:0]   r_in_byte;
    logic                         r_in_first;
    logic                         r_in_last;
    logic                         r_out_valid, n_out_valid;
    logic [brc_pkg::TERM_W-1:0]   r_out_checksum;

    logic                         fire;
    logic                         load;
    brc_pkg::t_step               step;
    logic [brc_pkg::TERM_W-1:0]   term;

    // A byte that emits nothing never waits on the output side.
    assign fire = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign load = fire && r_in_last;
    assign o_s_tready = !r_in_valid || fire;

    assign step.fire      = fire;
    assign step.first     = r_in_first;
    assign step.data_byte = r_in_byte;

    brc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_term  (term)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte  <= i_s_tdata;
            r_in_first <= i_s_tuser;
            r_in_last  <= i_s_tlast;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_checksum <= term;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_checksum;

    `ASSERT_NEXT(a_last_loads_out, i_clk, i_rst_n, load, r_out_valid)
    `ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, load && r_out_valid, i_m_tready)
    `ASSERT_IMPLIES(a_residue_range, i_clk, i_rst_n, r_out_valid, r_out_checksum != brc_pkg::MODULUS)
    `ASSERT_IMPLIES(a_fire_needs_item, i_clk, i_rst_n, fire, r_in_valid)

endmodule
